[rtl/cpb_pkg.sv]
package cpb_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int COORD_BITS   = 24;
  localparam int FIELD_W      = 24;
  localparam int AREA_W       = 56;

  localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int IDX_W  = $clog2(MAX_VERTICES);
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int HALF_W = DIFF_W;
  localparam int NRM_W  = 2 * DIFF_W;
  localparam int OPND_W = DIFF_W + 1;
  localparam int MUL_W  = 2 * OPND_W;
  localparam int ACC_W  = 4 * HALF_W + 2;
  localparam int ROOT_W = ACC_W / 2;
  localparam int SUM_W  = COORD_BITS + CNT_W;
  localparam int ASUM_W = ROOT_W + CNT_W;
  localparam int STEP_W = $clog2(ROOT_W + 2);

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_NEG    = 2'd1;
  localparam logic [1:0] ST_MULTI_NEG = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [NRM_W-1:0]      nrm_t;
  typedef logic signed [SUM_W-1:0]      sum_t;
  typedef logic signed [ACC_W-1:0]      acc_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vertex_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_ROTATE = 2'd1,
    CELL_INSERT = 2'd2
  } cell_op_e;

  typedef struct packed {
    cell_op_e           op;
    logic [CNT_W-1:0]   ins;
    logic [CNT_W-1:0]   cnt;
  } cell_ctrl_t;

  function automatic diff_t sub_c(coord_t l, coord_t r);
    return diff_t'(l) - diff_t'(r);
  endfunction

  function automatic logic [NRM_W-1:0] mag_n(nrm_t v);
    return v[NRM_W-1] ? NRM_W'(-v) : NRM_W'(v);
  endfunction

endpackage

[rtl/cpb_cell.sv]
module cpb_cell (
  input  logic                        clk_i,
  input  cpb_pkg::cell_ctrl_t         ctrl_i,
  input  logic [cpb_pkg::IDX_W-1:0]   idx_i,
  input  cpb_pkg::vertex_t            p_i,
  input  cpb_pkg::vertex_t            prev_i,
  input  cpb_pkg::vertex_t            next_i,
  input  cpb_pkg::vertex_t            head_i,
  output cpb_pkg::vertex_t            v_o,
  output logic                        match_o
);
  import cpb_pkg::*;

  vertex_t          v_q;
  logic [CNT_W-1:0] idx;
  logic             last;

  assign idx  = CNT_W'(idx_i);
  assign last = (idx == ctrl_i.cnt - CNT_W'(1));

  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      CELL_HOLD: ;
      // ring closes at the last occupied cell
      CELL_ROTATE: v_q <= last ? head_i : next_i;
      CELL_INSERT: begin
        if (idx > ctrl_i.ins) begin
          v_q <= prev_i;
        end else if (idx == ctrl_i.ins) begin
          v_q <= p_i;
        end
      end
      default: ;
    endcase
  end

  assign match_o = (idx < ctrl_i.cnt) && (v_q == p_i);
  assign v_o     = v_q;

endmodule

[rtl/cpb_div.sv]
module cpb_div (
  input  logic                         clk_i,
  input  logic                         load_i,
  input  logic                         step_i,
  input  cpb_pkg::sum_t                sum_i,
  input  logic [cpb_pkg::CNT_W-1:0]    cnt_i,
  output cpb_pkg::coord_t              q_o
);
  import cpb_pkg::*;

  logic [SUM_W-1:0] num_q;
  logic [CNT_W-1:0] rem_q;
  logic             neg_q;
  logic [CNT_W:0]   rem_sh;
  logic             qbit;

  assign rem_sh = {rem_q, num_q[SUM_W-1]};
  assign qbit   = rem_sh >= {1'b0, cnt_i};

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      // rounding bias, halves away from zero
      num_q <= (sum_i[SUM_W-1] ? SUM_W'(-sum_i) : SUM_W'(sum_i)) + SUM_W'(cnt_i >> 1);
      rem_q <= '0;
      neg_q <= sum_i[SUM_W-1];
    end else if (step_i) begin
      rem_q <= qbit ? CNT_W'(rem_sh - {1'b0, cnt_i}) : CNT_W'(rem_sh);
      num_q <= {num_q[SUM_W-2:0], qbit};
    end
  end

  assign q_o = coord_t'(neg_q ? -num_q : num_q);

endmodule

[rtl/cpb_sqrt.sv]
module cpb_sqrt (
  input  logic                         clk_i,
  input  logic                         load_i,
  input  logic                         step_i,
  input  logic [cpb_pkg::ACC_W-1:0]    rad_i,
  output logic [cpb_pkg::ROOT_W-1:0]   root_o
);
  import cpb_pkg::*;

  logic [ACC_W-1:0]  rad_q;
  logic [ROOT_W+1:0] rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [ROOT_W+1:0] rem_sh;
  logic [ROOT_W+1:0] trial;
  logic              fits;

  assign rem_sh = {rem_q[ROOT_W-1:0], rad_q[ACC_W-1 -: 2]};
  assign trial  = {root_q, 2'b01};
  assign fits   = rem_sh >= trial;

  // one root bit per step, radicand consumed two bits at a time
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (step_i) begin
      rad_q  <= rad_q << 2;
      rem_q  <= fits ? rem_sh - trial : rem_sh;
      root_q <= {root_q[ROOT_W-2:0], fits};
    end
  end

  assign root_o = root_q;

endmodule

[rtl/convex_polygon_builder.sv]
// Builds a convex polygon one 3D point per request. The vertices live in a row of cells that
// shift for insertion and rotate as a ring to walk the edges; one shared 26x26 multiplier
// forms the cross products and the 102-bit dot and square sums, three lanes divide the
// coordinate sums for the centroid, and a one-bit-per-cycle unit takes each triangle's root.
// A request walks the edges when three or more vertices are stored, then computes the centroid
// and the area once at least three are held; duplicates and full-store requests skip the edge
// walk. The next request is taken while the previous result waits in the output register.
module convex_polygon_builder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        start_new_i,
  input  logic [23:0] point_x_i,
  input  logic [23:0] point_y_i,
  input  logic [23:0] point_z_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        duplicate_o,
  output logic [4:0]  insert_index_o,
  output logic [4:0]  vertex_count_o,
  output logic [1:0]  status_o,
  output logic [23:0] center_x_o,
  output logic [23:0] center_y_o,
  output logic [23:0] center_z_o,
  output logic [55:0] polygon_area_o
);
  import cpb_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_DUP   = 10'b0000000010,
    S_DIFF  = 10'b0000000100,
    S_CROSS = 10'b0000001000,
    S_DOT   = 10'b0000010000,
    S_INS   = 10'b0000100000,
    S_SUM   = 10'b0001000000,
    S_DIV   = 10'b0010000000,
    S_SQRT  = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_e;

  typedef enum logic [1:0] {
    MODE_END    = 2'd0,
    MODE_NORMAL = 2'd1,
    MODE_EDGE   = 2'd2,
    MODE_AREA   = 2'd3
  } mode_e;

  typedef logic signed [OPND_W-1:0] opnd_t;
  typedef logic signed [MUL_W-1:0]  mul_t;

  localparam logic [STEP_W-1:0] CROSS_LAST = STEP_W'(7);
  localparam logic [STEP_W-1:0] DOT_LAST   = STEP_W'(13);

  state_e             state_q, state_d;
  mode_e              mode_q, mode_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic [CNT_W-1:0]   edge_q, edge_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CNT_W-1:0]   ins_q, ins_d;
  logic [1:0]         status_q, status_d;
  logic               dup_q, dup_d;
  logic               seen_q, seen_d;
  logic               multi_q, multi_d;
  logic               out_valid_q, out_valid_d;
  nrm_t               normal_q [3];
  nrm_t               normal_d [3];
  logic               mv_q;

  cell_ctrl_t            cell_ctrl;
  vertex_t               cell_v [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] cell_match;

  vertex_t  p_q;
  diff_t    u1_q [3];
  diff_t    u2_q [3];
  nrm_t     n_q [3];
  acc_t     acc_q;
  mul_t     mul_q;
  logic [1:0] mk_q, msh_q;
  logic     msub_q, mneg_q, mdot_q;
  sum_t     s_q [3];
  coord_t   c_q [3];
  coord_t   div_q [3];
  logic [ASUM_W-1:0] asum_q;
  logic [ROOT_W-1:0] root;

  coord_t av [3];
  coord_t bv [3];
  coord_t pv [3];

  logic sum_clr, div_load, div_step, sq_load, sq_step, out_load;

  opnd_t      op_a, op_b;
  logic       iss_v, iss_sub, iss_neg, iss_dot;
  logic [1:0] iss_k, iss_sh;
  logic [NRM_W-1:0] ma, mb;
  logic [1:0] dk;

  logic [ASUM_W:0]          area_half;
  logic [ASUM_W+AREA_W-1:0] area_wide;
  logic [AREA_W-1:0]        area_val;
  acc_t                     acc_add;

  // vertex ring
  for (genvar g = 0; g < MAX_VERTICES; g++) begin : g_cell
    localparam int PREV = (g == 0) ? 0 : g - 1;
    localparam int NEXT = (g == MAX_VERTICES - 1) ? 0 : g + 1;
    cpb_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cell_ctrl),
      .idx_i   (IDX_W'(g)),
      .p_i     (p_q),
      .prev_i  (cell_v[PREV]),
      .next_i  (cell_v[NEXT]),
      .head_i  (cell_v[0]),
      .v_o     (cell_v[g]),
      .match_o (cell_match[g])
    );
  end

  assign av = '{cell_v[0].x, cell_v[0].y, cell_v[0].z};
  assign bv = '{cell_v[1].x, cell_v[1].y, cell_v[1].z};
  assign pv = '{p_q.x, p_q.y, p_q.z};

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    step_d      = step_q;
    edge_d      = edge_q;
    cnt_d       = cnt_q;
    ins_d       = ins_q;
    status_d    = status_q;
    dup_d       = dup_q;
    seen_d      = seen_q;
    multi_d     = multi_q;
    out_valid_d = out_valid_q;
    normal_d    = normal_q;
    cell_ctrl   = '{op: CELL_HOLD, ins: ins_q, cnt: cnt_q};
    sum_clr     = 1'b0;
    div_load    = 1'b0;
    div_step    = 1'b0;
    sq_load     = 1'b0;
    sq_step     = 1'b0;
    out_load    = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d  = S_DUP;
          mode_d   = MODE_END;
          dup_d    = 1'b0;
          ins_d    = '0;
          status_d = ST_OK;
          seen_d   = 1'b0;
          multi_d  = 1'b0;
          if (start_new_i) begin
            cnt_d    = '0;
            normal_d = '{default: '0};
          end
        end
      end
      S_DUP: begin
        if (|cell_match || cnt_q >= CNT_W'(MAX_VERTICES)) begin
          if (|cell_match) begin
            dup_d = 1'b0 | 1'b1;
          end else begin
            status_d = ST_FULL;
          end
          if (cnt_q >= CNT_W'(3)) begin
            state_d = S_SUM;
            edge_d  = '0;
            sum_clr = 1'b1;
          end else begin
            state_d = S_DONE;
          end
        end else if (cnt_q < CNT_W'(2)) begin
          ins_d   = cnt_q;
          state_d = S_INS;
        end else if (cnt_q == CNT_W'(2)) begin
          ins_d   = cnt_q;
          mode_d  = MODE_NORMAL;
          state_d = S_DIFF;
        end else begin
          mode_d  = MODE_EDGE;
          edge_d  = '0;
          state_d = S_DIFF;
        end
      end
      S_DIFF: begin
        step_d  = '0;
        state_d = S_CROSS;
      end
      S_CROSS: begin
        step_d = step_q + STEP_W'(1);
        if (step_q == CROSS_LAST) begin
          step_d = '0;
          if (mode_q == MODE_NORMAL) begin
            normal_d = n_q;
            state_d  = S_INS;
          end else begin
            state_d = S_DOT;
          end
        end
      end
      S_DOT: begin
        step_d = step_q + STEP_W'(1);
        if (step_q == DOT_LAST) begin
          step_d = '0;
          if (mode_q == MODE_EDGE) begin
            if (acc_q[ACC_W-1]) begin
              seen_d  = 1'b1;
              multi_d = multi_q | seen_q;
              ins_d   = edge_q + CNT_W'(1);
            end
            cell_ctrl.op = CELL_ROTATE;
            edge_d       = edge_q + CNT_W'(1);
            state_d      = (edge_q == cnt_q - CNT_W'(1)) ? S_INS : S_DIFF;
          end else begin
            state_d = S_SQRT;
          end
        end
      end
      S_INS: begin
        cell_ctrl.op = CELL_INSERT;
        cnt_d        = cnt_q + CNT_W'(1);
        if (mode_q == MODE_EDGE) begin
          status_d = multi_q ? ST_MULTI_NEG : (seen_q ? ST_OK : ST_NO_NEG);
        end
        if (cnt_q >= CNT_W'(2)) begin
          state_d = S_SUM;
          edge_d  = '0;
          sum_clr = 1'b1;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SUM: begin
        if (edge_q == cnt_q) begin
          div_load = 1'b1;
          step_d   = '0;
          state_d  = S_DIV;
        end else begin
          cell_ctrl.op = CELL_ROTATE;
          edge_d       = edge_q + CNT_W'(1);
        end
      end
      S_DIV: begin
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(SUM_W)) begin
          step_d  = '0;
          edge_d  = '0;
          mode_d  = MODE_AREA;
          state_d = S_DIFF;
        end else begin
          div_step = 1'b1;
        end
      end
      S_SQRT: begin
        step_d  = step_q + STEP_W'(1);
        sq_load = (step_q == '0);
        sq_step = (step_q != '0) && (step_q <= STEP_W'(ROOT_W));
        if (step_q == STEP_W'(ROOT_W + 1)) begin
          step_d       = '0;
          cell_ctrl.op = CELL_ROTATE;
          edge_d       = edge_q + CNT_W'(1);
          state_d      = (edge_q == cnt_q - CNT_W'(1)) ? S_DONE : S_DIFF;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= MODE_END;
      step_q      <= '0;
      edge_q      <= '0;
      cnt_q       <= '0;
      ins_q       <= '0;
      status_q    <= ST_OK;
      dup_q       <= 1'b0;
      seen_q      <= 1'b0;
      multi_q     <= 1'b0;
      out_valid_q <= 1'b0;
      normal_q    <= '{default: '0};
      mv_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      step_q      <= step_d;
      edge_q      <= edge_d;
      cnt_q       <= cnt_d;
      ins_q       <= ins_d;
      status_q    <= status_d;
      dup_q       <= dup_d;
      seen_q      <= seen_d;
      multi_q     <= multi_d;
      out_valid_q <= out_valid_d;
      normal_q    <= normal_d;
      mv_q        <= iss_v;
    end
  end

  // operand selection for the shared multiplier
  assign dk = step_q[3:2];
  always_comb begin
    op_a    = '0;
    op_b    = '0;
    iss_v   = 1'b0;
    iss_sub = step_q[0];
    iss_k   = 2'(step_q[2:1]);
    iss_sh  = 2'd0;
    iss_neg = 1'b0;
    iss_dot = 1'b0;
    ma      = mag_n(n_q[dk]);
    mb      = (mode_q == MODE_EDGE) ? mag_n(normal_q[dk]) : ma;
    if (state_q == S_CROSS && step_q < STEP_W'(6)) begin
      iss_v = 1'b1;
      case (step_q[2:0])
        3'd0: begin op_a = opnd_t'(u1_q[1]); op_b = opnd_t'(u2_q[2]); end
        3'd1: begin op_a = opnd_t'(u1_q[2]); op_b = opnd_t'(u2_q[1]); end
        3'd2: begin op_a = opnd_t'(u1_q[2]); op_b = opnd_t'(u2_q[0]); end
        3'd3: begin op_a = opnd_t'(u1_q[0]); op_b = opnd_t'(u2_q[2]); end
        3'd4: begin op_a = opnd_t'(u1_q[0]); op_b = opnd_t'(u2_q[1]); end
        3'd5: begin op_a = opnd_t'(u1_q[1]); op_b = opnd_t'(u2_q[0]); end
        default: ;
      endcase
    end else if (state_q == S_DOT && step_q < STEP_W'(12)) begin
      iss_v   = 1'b1;
      iss_dot = 1'b1;
      iss_neg = (mode_q == MODE_EDGE) && (n_q[dk][NRM_W-1] ^ normal_q[dk][NRM_W-1]);
      case (step_q[1:0])
        2'd0: begin
          op_a = {1'b0, ma[HALF_W-1:0]};  op_b = {1'b0, mb[HALF_W-1:0]};
        end
        2'd1: begin
          op_a = {1'b0, ma[HALF_W-1:0]};  op_b = {1'b0, mb[NRM_W-1:HALF_W]};
          iss_sh = 2'd1;
        end
        2'd2: begin
          op_a = {1'b0, ma[NRM_W-1:HALF_W]}; op_b = {1'b0, mb[HALF_W-1:0]};
          iss_sh = 2'd1;
        end
        2'd3: begin
          op_a = {1'b0, ma[NRM_W-1:HALF_W]}; op_b = {1'b0, mb[NRM_W-1:HALF_W]};
          iss_sh = 2'd2;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (msh_q)
      2'd1:    acc_add = acc_t'(mul_q) <<< HALF_W;
      2'd2:    acc_add = acc_t'(mul_q) <<< (2 * HALF_W);
      default: acc_add = acc_t'(mul_q);
    endcase
  end

  assign area_half = ({1'b0, asum_q} + (ASUM_W + 1)'(1)) >> 1;
  assign area_wide = (ASUM_W + AREA_W)'(area_half);
  assign area_val  = (area_wide > (ASUM_W + AREA_W)'({AREA_W{1'b1}})) ?
                     {AREA_W{1'b1}} : area_wide[AREA_W-1:0];

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      p_q <= '{x: coord_t'(point_x_i[COORD_BITS-1:0]),
               y: coord_t'(point_y_i[COORD_BITS-1:0]),
               z: coord_t'(point_z_i[COORD_BITS-1:0])};
    end

    if (state_q == S_DIFF) begin
      for (int k = 0; k < 3; k++) begin
        if (mode_q == MODE_AREA) begin
          u1_q[k] <= sub_c(av[k], c_q[k]);
          u2_q[k] <= sub_c(bv[k], c_q[k]);
        end else begin
          u1_q[k] <= sub_c(bv[k], av[k]);
          u2_q[k] <= sub_c(pv[k], av[k]);
        end
        n_q[k] <= '0;
      end
      acc_q <= '0;
    end else if (mv_q) begin
      if (mdot_q) begin
        acc_q <= mneg_q ? acc_q - acc_add : acc_q + acc_add;
      end else begin
        for (int k = 0; k < 3; k++) begin
          if (mk_q == 2'(k)) begin
            n_q[k] <= msub_q ? n_q[k] - nrm_t'(mul_q) : n_q[k] + nrm_t'(mul_q);
          end
        end
      end
    end

    mul_q  <= op_a * op_b;
    mk_q   <= iss_k;
    msh_q  <= iss_sh;
    msub_q <= iss_sub;
    mneg_q <= iss_neg;
    mdot_q <= iss_dot;

    if (sum_clr) begin
      s_q    <= '{default: '0};
      asum_q <= '0;
    end else if (state_q == S_SUM && edge_q != cnt_q) begin
      for (int k = 0; k < 3; k++) begin
        s_q[k] <= s_q[k] + sum_t'(av[k]);
      end
    end else if (state_q == S_SQRT && step_q == STEP_W'(ROOT_W + 1)) begin
      asum_q <= asum_q + ASUM_W'(root);
    end

    if (state_q == S_DIV && step_q == STEP_W'(SUM_W)) begin
      c_q <= div_q;
    end

    if (out_load) begin
      duplicate_o    <= dup_q;
      insert_index_o <= 5'(ins_q);
      vertex_count_o <= 5'(cnt_q);
      status_o       <= status_q;
      if (cnt_q >= CNT_W'(3)) begin
        center_x_o     <= FIELD_W'(c_q[0]);
        center_y_o     <= FIELD_W'(c_q[1]);
        center_z_o     <= FIELD_W'(c_q[2]);
        polygon_area_o <= area_val;
      end else begin
        center_x_o     <= '0;
        center_y_o     <= '0;
        center_z_o     <= '0;
        polygon_area_o <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  // centroid lanes
  for (genvar k = 0; k < 3; k++) begin : g_div
    cpb_div u_div (
      .clk_i  (clk_i),
      .load_i (div_load),
      .step_i (div_step),
      .sum_i  (s_q[k]),
      .cnt_i  (cnt_q),
      .q_o    (div_q[k])
    );
  end

  cpb_sqrt u_sqrt (
    .clk_i  (clk_i),
    .load_i (sq_load),
    .step_i (sq_step),
    .rad_i  (ACC_W'(acc_q)),
    .root_o (root)
  );

endmodule

[rtl/cpb_checker.sv]
module cpb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        duplicate_o,
  input logic [4:0]  insert_index_o,
  input logic [4:0]  vertex_count_o,
  input logic [1:0]  status_o,
  input logic [23:0] center_x_o,
  input logic [23:0] center_y_o,
  input logic [23:0] center_z_o,
  input logic [55:0] polygon_area_o
);
  import cpb_pkg::*;

  // a waiting result's count, area and status must not change under a stall
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(vertex_count_o)
      && $stable(polygon_area_o) && $stable(status_o))
    else $error("result changed while stalled");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> vertex_count_o <= 5'(MAX_VERTICES) && insert_index_o <= vertex_count_o)
    else $error("vertex count or insert position out of range");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FULL |->
      vertex_count_o == 5'(MAX_VERTICES) && insert_index_o == '0 && !duplicate_o)
    else $error("full status with wrong count");

  a_dup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && duplicate_o |-> status_o == ST_OK && insert_index_o == '0)
    else $error("duplicate request reported an insertion");

  a_small: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && vertex_count_o < 5'd3 |->
      center_x_o == '0 && center_y_o == '0 && center_z_o == '0 && polygon_area_o == '0)
    else $error("centroid or area set below three vertices");

endmodule

bind convex_polygon_builder cpb_checker u_cpb_checker (.*);
